// ===== rtl/core/set_associative_lru_cache_macros.svh =====
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MACROS_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SALC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache check failed");

// next-cycle implication, checked outside reset
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache check failed");

`endif

// ===== rtl/core/salc_pkg.sv =====
package salc_pkg;

    localparam int MAX_BLOCK_WORDS = 16;
    localparam int MAX_SETS        = 32;
    localparam int MAX_WAYS        = 8;
    localparam int MEM_WORDS       = 65536;

    localparam int WORD_W  = $clog2(MAX_BLOCK_WORDS);
    localparam int SET_W   = $clog2(MAX_SETS);
    localparam int WAY_W   = $clog2(MAX_WAYS);
    localparam int MEM_AW  = $clog2(MEM_WORDS);
    localparam int LINE_AW = SET_W + WAY_W + WORD_W;
    localparam int CNT_W   = WORD_W + 1;
    localparam int TAG_W   = 16;
    localparam int DATA_W  = 32;
    localparam int OUT_W   = 56;

    localparam logic [1:0] REQ_READ    = 2'd0;
    localparam logic [1:0] REQ_WRITE   = 2'd1;
    localparam logic [1:0] REQ_PRELOAD = 2'd2;

    localparam logic [1:0] REG_BLOCK_LOG2 = 2'd0;
    localparam logic [1:0] REG_SETS_LOG2  = 2'd1;
    localparam logic [1:0] REG_WAYS_LOG2  = 2'd2;

    typedef enum logic [2:0] {
        ACT_C2P     = 3'd0,
        ACT_P2C     = 3'd1,
        ACT_M2C     = 3'd2,
        ACT_C2M     = 3'd3,
        ACT_DISCARD = 3'd4
    } action_t;

    typedef struct packed {
        logic    clr_run;
        logic    req_load;
        logic    preload;
        logic    tag_rd;
        logic    compare;
        logic    wb_run;
        logic    fill_run;
        logic    fill_commit;
        logic    touch;
        logic    word_wr;
        logic    word_rd;
        logic    emit;
        action_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic hit_now;
        logic vic_valid_now;
        logic vic_dirty_now;
        logic vic_dirty;
        logic copy_done;
        logic out_free;
        logic is_write;
    } status_t;

endpackage

// ===== rtl/core/set_associative_lru_cache.sv =====
// Write-back, write-allocate set-associative cache with full LRU order per set in front of a
// 64K-word backing memory. After reset the backing memory is cleared one word a cycle, during
// which no access is accepted. A preload writes the backing memory directly and leaves the
// cache idle. A hit read goes through lookup, compare, access and read emit, and a hit write
// through lookup, compare and access; a miss adds the fill, a discard event for a clean valid
// victim and a write-back for a dirty victim, and both copies go one word a cycle through
// each memory. Events of one access leave in order: victim write-back or discard, fill,
// then the processor transfer with tlast.
module set_associative_lru_cache
    import salc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address, write_data
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // action, start_address, size_words, read_data
    output logic        m_axis_tlast
);

`include "set_associative_lru_cache_macros.svh"

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    salc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_type  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    salc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_type       (s_axis_tuser),
        .in_address    (s_axis_tdata[15:0]),
        .in_write_data (s_axis_tdata[47:16]),
        .cmd           (cmd),
        .st            (st),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata),
        .out_last      (m_axis_tlast)
    );

    `SALC_ASSERT_NOW(a_no_overwrite, cmd.emit, st.out_free)
    `SALC_ASSERT_NOW(a_idle_no_copy, s_axis_tready, !(cmd.wb_run || cmd.fill_run))
    `SALC_ASSERT_NEXT(a_busy_after_access, s_axis_tvalid && s_axis_tready && !s_axis_tuser[1],
        !s_axis_tready)

endmodule

// ===== rtl/core/salc_ctrl.sv =====
module salc_ctrl
    import salc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_type,
    output logic       in_ready,
    input  status_t    st,
    output cmd_t       cmd
);

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_LOOKUP    = 10'b0000000100,
        S_COMPARE   = 10'b0000001000,
        S_WB        = 10'b0000010000,
        S_EMIT_VIC  = 10'b0000100000,
        S_FILL      = 10'b0001000000,
        S_EMIT_FILL = 10'b0010000000,
        S_ACCESS    = 10'b0100000000,
        S_EMIT_RD   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_kind = ACT_C2P;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_run = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    cmd.preload  = (in_type == REQ_PRELOAD);
                    if (!in_type[1])
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                cmd.tag_rd = 1'b1;
                state_next = S_COMPARE;
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                priority if (st.hit_now)
                begin
                    state_next = S_ACCESS;
                end
                else if (st.vic_valid_now)
                begin
                    state_next = st.vic_dirty_now ? S_WB : S_EMIT_VIC;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_WB:
            begin
                cmd.wb_run = 1'b1;
                if (st.copy_done)
                begin
                    state_next = S_EMIT_VIC;
                end
            end
            S_EMIT_VIC:
            begin
                cmd.emit_kind = st.vic_dirty ? ACT_C2M : ACT_DISCARD;
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill_run = 1'b1;
                if (st.copy_done)
                begin
                    state_next = S_EMIT_FILL;
                end
            end
            S_EMIT_FILL:
            begin
                cmd.emit_kind = ACT_M2C;
                if (st.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.fill_commit = 1'b1;
                    state_next      = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                cmd.emit_kind = ACT_P2C;
                if (st.is_write)
                begin
                    if (st.out_free)
                    begin
                        cmd.touch   = 1'b1;
                        cmd.word_wr = 1'b1;
                        cmd.emit    = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    cmd.touch   = 1'b1;
                    cmd.word_rd = 1'b1;
                    state_next  = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_kind = ACT_C2P;
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/salc_dp.sv =====
module salc_dp
    import salc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic [1:0]         in_type,
    input  logic [TAG_W-1:0]   in_address,
    input  logic [DATA_W-1:0]  in_write_data,
    input  cmd_t               cmd,
    output status_t            st,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [OUT_W-1:0]   out_data,
    output logic               out_last
);

    logic [2:0]        bwl_reg;
    logic [2:0]        sl_reg;
    logic [1:0]        wl_reg;
    logic [1:0]        type_reg;
    logic [TAG_W-1:0]  addr_reg;
    logic [DATA_W-1:0] wdata_reg;

    logic [2:0]        b_eff;
    logic [2:0]        s_eff;
    logic [3:0]        bs;
    logic [CNT_W-1:0]  bsize;
    logic [3:0]        ways;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic [TAG_W-1:0]  base;
    logic [WORD_W-1:0] offset;

    logic [MAX_WAYS*TAG_W-1:0] tag_mem [MAX_SETS];
    logic [MAX_WAYS*TAG_W-1:0] tag_row_q;
    logic [DATA_W-1:0]         word_mem [1 << LINE_AW];
    logic [DATA_W-1:0]         word_q;
    logic [DATA_W-1:0]         back_mem [MEM_WORDS];
    logic [DATA_W-1:0]         back_q;

    logic [MAX_WAYS-1:0] valid_reg [MAX_SETS];
    logic [MAX_WAYS-1:0] dirty_reg [MAX_SETS];
    logic [WAY_W-1:0]    lru_reg   [MAX_SETS][MAX_WAYS];

    logic [WAY_W-1:0]  way_reg;
    logic              vic_dirty_reg;
    logic [TAG_W-1:0]  vaddr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              pend_reg;
    logic [WORD_W-1:0] idx_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic              clr_done_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic [MAX_WAYS-1:0] hv;
    logic [WAY_W-1:0]    hit_way;
    logic                hit;
    logic [WAY_W-1:0]    vic_way;
    logic [TAG_W-1:0]    vic_tag;
    logic [TAG_W-1:0]    vaddr;
    logic                run;
    logic                issue;

    logic [MAX_WAYS-1:0] tmatch;
    logic [MAX_WAYS-1:0] after;
    logic                tfound;
    logic [WAY_W-1:0]    lru_new [MAX_WAYS];
    logic [MAX_WAYS*TAG_W-1:0] tag_row_new;

    logic              bk_we;
    logic [MEM_AW-1:0] bk_wa;
    logic [DATA_W-1:0] bk_wd;
    logic              wd_we;
    logic [LINE_AW-1:0] wd_wa;
    logic [DATA_W-1:0] wd_wd;
    logic              wd_re;
    logic [LINE_AW-1:0] wd_ra;

    logic [TAG_W-1:0]  ev_addr;
    logic [4:0]        ev_size;
    logic [DATA_W-1:0] ev_data;

    // geometry
    always_comb
    begin
        b_eff   = (bwl_reg > 3'd4) ? 3'd4 : bwl_reg;
        s_eff   = (sl_reg > 3'd5) ? 3'd5 : sl_reg;
        bs      = {1'b0, b_eff} + {1'b0, s_eff};
        bsize   = CNT_W'(1) << b_eff;
        ways    = 4'd1 << wl_reg;
        set_idx = SET_W'(addr_reg >> b_eff) & SET_W'((6'd1 << s_eff) - 6'd1);
        tag     = addr_reg >> bs;
        base    = addr_reg & ~(TAG_W'(bsize) - TAG_W'(1));
        offset  = WORD_W'(addr_reg) & WORD_W'(bsize - CNT_W'(1));
    end

    // lookup
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            hv[j] = (j < int'(ways)) && valid_reg[set_idx][j]
                    && (tag_row_q[j*TAG_W +: TAG_W] == tag);
        end
        for (int j = MAX_WAYS - 1; j >= 0; j--)
        begin
            if (hv[j])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(j);
            end
        end
        vic_way = lru_reg[set_idx][0];
        vic_tag = tag_row_q[vic_way*TAG_W +: TAG_W];
        vaddr   = (vic_tag << bs) | (TAG_W'(set_idx) << b_eff);
    end

    // lru update and tag row merge
    always_comb
    begin
        for (int p = 0; p < MAX_WAYS; p++)
        begin
            tmatch[p] = (p < int'(ways)) && (lru_reg[set_idx][p] == way_reg);
        end
        after[0] = tmatch[0];
        for (int p = 1; p < MAX_WAYS; p++)
        begin
            after[p] = after[p-1] | tmatch[p];
        end
        tfound = |tmatch;
        for (int p = 0; p < MAX_WAYS; p++)
        begin
            if (tfound && (p == int'(ways) - 1))
            begin
                lru_new[p] = way_reg;
            end
            else if (tfound && after[p] && (p < int'(ways) - 1))
            begin
                lru_new[p] = lru_reg[set_idx][(p + 1) % MAX_WAYS];
            end
            else
            begin
                lru_new[p] = lru_reg[set_idx][p];
            end
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            tag_row_new[w*TAG_W +: TAG_W] = (WAY_W'(w) == way_reg)
                ? tag : tag_row_q[w*TAG_W +: TAG_W];
        end
    end

    // memory port selection
    always_comb
    begin
        run   = cmd.wb_run | cmd.fill_run;
        issue = run && (cnt_reg < bsize);

        bk_we = 1'b0;
        bk_wa = addr_reg;
        bk_wd = wdata_reg;
        if (cmd.clr_run && !clr_done_reg)
        begin
            bk_we = 1'b1;
            bk_wa = clr_cnt_reg;
            bk_wd = '0;
        end
        else if (cmd.preload)
        begin
            bk_we = 1'b1;
            bk_wa = in_address;
            bk_wd = in_write_data;
        end
        else if (cmd.wb_run && pend_reg)
        begin
            bk_we = 1'b1;
            bk_wa = vaddr_reg + MEM_AW'(idx_reg);
            bk_wd = word_q;
        end

        wd_we = 1'b0;
        wd_wa = {set_idx, way_reg, offset};
        wd_wd = wdata_reg;
        if (cmd.fill_run && pend_reg)
        begin
            wd_we = 1'b1;
            wd_wa = {set_idx, way_reg, idx_reg};
            wd_wd = back_q;
        end
        else if (cmd.word_wr)
        begin
            wd_we = 1'b1;
        end

        wd_re = cmd.word_rd | (cmd.wb_run && issue);
        wd_ra = cmd.wb_run ? {set_idx, way_reg, WORD_W'(cnt_reg)}
                           : {set_idx, way_reg, offset};
    end

    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            back_mem[bk_wa] <= bk_wd;
        end
        if (cmd.fill_run && issue)
        begin
            back_q <= back_mem[base + MEM_AW'(cnt_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wd_we)
        begin
            word_mem[wd_wa] <= wd_wd;
        end
        if (wd_re)
        begin
            word_q <= word_mem[wd_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_commit)
        begin
            tag_mem[set_idx] <= tag_row_new;
        end
        if (cmd.tag_rd)
        begin
            tag_row_q <= tag_mem[set_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            type_reg  <= in_type;
            addr_reg  <= in_address;
            wdata_reg <= in_write_data;
        end
        if (cmd.compare)
        begin
            way_reg       <= hit ? hit_way : vic_way;
            vic_dirty_reg <= dirty_reg[set_idx][vic_way];
            vaddr_reg     <= vaddr;
        end
        if (issue)
        begin
            idx_reg <= WORD_W'(cnt_reg);
        end
        if (cmd.emit)
        begin
            out_data_reg <= {ev_data, ev_size, ev_addr, cmd.emit_kind};
            out_last_reg <= (cmd.emit_kind == ACT_C2P) || (cmd.emit_kind == ACT_P2C);
        end
    end

    always_comb
    begin
        unique case (cmd.emit_kind)
            ACT_C2M, ACT_DISCARD:
            begin
                ev_addr = vaddr_reg;
                ev_size = bsize;
                ev_data = '0;
            end
            ACT_M2C:
            begin
                ev_addr = base;
                ev_size = bsize;
                ev_data = '0;
            end
            ACT_P2C:
            begin
                ev_addr = addr_reg;
                ev_size = 5'd1;
                ev_data = '0;
            end
            default:
            begin
                ev_addr = addr_reg;
                ev_size = 5'd1;
                ev_data = word_q;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bwl_reg       <= 3'd2;
            sl_reg        <= 3'd0;
            wl_reg        <= 2'd0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            clr_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SETS; i++)
            begin
                valid_reg[i] <= '0;
                dirty_reg[i] <= '0;
                for (int p = 0; p < MAX_WAYS; p++)
                begin
                    lru_reg[i][p] <= WAY_W'(p);
                end
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_BLOCK_LOG2: bwl_reg <= cfg_data;
                    REG_SETS_LOG2:  sl_reg  <= cfg_data;
                    REG_WAYS_LOG2:  wl_reg  <= cfg_data[1:0];
                    default:        ;
                endcase
            end
            if (cmd.clr_run && !clr_done_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
                if (clr_cnt_reg == MEM_AW'(MEM_WORDS - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (!run)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            pend_reg <= issue;
            if (cmd.fill_commit)
            begin
                valid_reg[set_idx][way_reg] <= 1'b1;
                dirty_reg[set_idx][way_reg] <= 1'b0;
            end
            if (cmd.word_wr)
            begin
                dirty_reg[set_idx][way_reg] <= 1'b1;
            end
            if (cmd.touch)
            begin
                for (int p = 0; p < MAX_WAYS; p++)
                begin
                    lru_reg[set_idx][p] <= lru_new[p];
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st               = '0;
        st.clr_done      = clr_done_reg;
        st.hit_now       = hit;
        st.vic_valid_now = valid_reg[set_idx][vic_way];
        st.vic_dirty_now = dirty_reg[set_idx][vic_way];
        st.vic_dirty     = vic_dirty_reg;
        st.copy_done     = run && (cnt_reg == bsize) && !pend_reg;
        st.out_free      = !out_valid_reg || out_ready;
        st.is_write      = (type_reg == REQ_WRITE);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule
